@@ rtl/pwlti_pkg.sv @@
// Shared types, field widths and codes of the piecewise linear time interpolator.
package pwlti_pkg;

   localparam int DEFAULT_MAX_POINTS = 256;

   localparam int TIME_W    = 32;
   localparam int VALUE_W   = 32;
   localparam int FRAC_W    = 16;
   localparam int INDEX_W   = 8;
   localparam int COUNT_W   = 9;
   localparam int CSR_IDX_W = 2;
   localparam int REGION_W  = 2;

   // opcodes of an input word
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CONST_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONST_VALUE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = 2'd2;

   localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = 9'd2;

   // result region codes
   localparam logic [REGION_W-1:0] REGION_CONST  = 2'd0;
   localparam logic [REGION_W-1:0] REGION_BEFORE = 2'd1;
   localparam logic [REGION_W-1:0] REGION_INTERP = 2'd2;
   localparam logic [REGION_W-1:0] REGION_HELD   = 2'd3;

   // one breakpoint as stored in the table memory
   typedef struct packed {
      logic [TIME_W-1:0]         bp_time;
      logic signed [VALUE_W-1:0] bp_value;
   } bp_type;

endpackage

@@ rtl/pwlti_if.sv @@
// Request and response channel interfaces of the interpolator.
interface pwlti_req_if;
   import pwlti_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      opcode;
   logic [INDEX_W-1:0]        point_index;
   logic [TIME_W-1:0]         point_time;
   logic signed [VALUE_W-1:0] point_value;
   logic [TIME_W-1:0]         query_time;

   modport source (output valid, opcode, point_index, point_time, point_value, query_time,
                   input ready);
   modport sink   (input valid, opcode, point_index, point_time, point_value, query_time,
                   output ready);
endinterface

interface pwlti_rsp_if;
   import pwlti_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] interp_value;
   logic [REGION_W-1:0]       region;

   modport source (output valid, interp_value, region, input ready);
   modport sink   (input valid, interp_value, region, output ready);
endinterface

@@ rtl/pwlti_table.sv @@
// Breakpoint table memory: one write port, one read port with registered data.
module pwlti_table #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  pwlti_pkg::bp_type wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output pwlti_pkg::bp_type rd_data
);
   import pwlti_pkg::*;

   bp_type mem [DEPTH];

   // store a breakpoint
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read one entry, data valid the next cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/pwlti_divider.sv @@
// Restoring divider for the Q0.16 segment fraction, one quotient bit per cycle.
module pwlti_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [pwlti_pkg::TIME_W-1:0]       num,
   input  logic [pwlti_pkg::TIME_W-1:0]       den,
   output logic                               done,
   output logic [pwlti_pkg::FRAC_W-1:0]       quot
);
   import pwlti_pkg::*;

   localparam int CW = $clog2(FRAC_W);

   logic              busy_ff;
   logic              done_ff;
   logic [CW-1:0]     cnt_ff;
   logic [TIME_W:0]   rem_ff;
   logic [FRAC_W-1:0] quot_ff;

   logic [TIME_W:0]   shifted;
   logic              fits;
   logic [TIME_W:0]   rem_in;

   // one restoring step: shift in a zero, subtract the divisor when it fits
   always_comb begin
      shifted = {rem_ff[TIME_W-1:0], 1'b0};
      fits    = shifted >= {1'b0, den};
      rem_in  = fits ? shifted - {1'b0, den} : shifted;
   end

   // control: busy flag, step count, done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(FRAC_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath: partial remainder and quotient bits (numerator is below the divisor)
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= {1'b0, num};
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[FRAC_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

@@ rtl/piecewise_linear_time_interpolator_core.sv @@
// Top level of the piecewise linear time interpolator: sequencer, registers, table and divider.
//
// A write word stores one breakpoint and clears the segment pointer; it gives no response. A
// query in constant mode goes straight to the done state with the constant value. A table
// query reads the breakpoint table from a single-read-port memory: it walks the segment
// pointer forward one breakpoint at a time, then loads the lower breakpoint, compares, and for
// an interpolated time runs a bit-serial fraction divider and a multiply; a time before the
// segment, on its upper breakpoint or past the end skips the divider and the multiply.
// Words are taken one at a time; the next word is accepted while a response still waits in
// the output register. The table needs no clearing pass: its entries must be written before
// they are queried.
module piecewise_linear_time_interpolator_core #(
   parameter int MAX_POINTS = pwlti_pkg::DEFAULT_MAX_POINTS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   pwlti_req_if.sink                            req_ch,
   pwlti_rsp_if.source                          rsp_ch,
   input  logic                                 csr_we,
   input  logic [pwlti_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pwlti_pkg::VALUE_W-1:0]        csr_wdata
);
   import pwlti_pkg::*;

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
   localparam int PROD_W = FRAC_W + 1 + VALUE_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_LOAD_LO,
      ST_EVAL,
      ST_DIV,
      ST_MUL,
      ST_SUM,
      ST_DONE
   } state_type;

   state_type                 state_ff;
   logic [IDX_W-1:0]          seg_ff;
   logic [TIME_W-1:0]         t_ff;
   bp_type                    hi_ff;
   bp_type                    lo_ff;
   logic [FRAC_W-1:0]         f_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [VALUE_W-1:0] res_ff;
   logic [REGION_W-1:0]       region_ff;
   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] out_value_ff;
   logic [REGION_W-1:0]       out_region_ff;

   logic                      mode_ff;
   logic signed [VALUE_W-1:0] const_ff;
   logic [COUNT_W-1:0]        count_ff;

   logic                      req_fire;
   logic                      out_free;
   logic [CNT_W-1:0]          n_cnt;
   logic [CNT_W-1:0]          seg_lim;
   logic [IDX_W-1:0]          seg_start;
   logic [IDX_W-1:0]          seg_inc;
   logic                      walk_adv;
   logic [CNT_W-1:0]          idx_ext;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   bp_type                    wr_data;
   logic                      rd_en;
   logic [IDX_W-1:0]          rd_addr;
   bp_type                    rd_data;
   logic                      div_start;
   logic                      div_done;
   logic [FRAC_W-1:0]         div_quot;
   logic [TIME_W-1:0]         div_num;
   logic [TIME_W-1:0]         div_den;
   logic signed [VALUE_W:0]   diff;
   logic signed [PROD_W-1:0]  prod_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         const_ff <= '0;
         count_ff <= POINT_COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CONST_MODE:  mode_ff  <= csr_wdata[0];
            CSR_CONST_VALUE: const_ff <= csr_wdata;
            CSR_POINT_COUNT: count_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake, point count limits and pointer arithmetic
   always_comb begin
      req_fire = req_ch.valid && req_ch.ready;
      out_free = !rsp_valid_ff || rsp_ch.ready;

      n_cnt = CNT_W'(count_ff);
      if (n_cnt < CNT_W'(2)) begin
         n_cnt = CNT_W'(2);
      end else if (n_cnt > CNT_W'(MAX_POINTS)) begin
         n_cnt = CNT_W'(MAX_POINTS);
      end
      seg_lim   = n_cnt - CNT_W'(2);
      seg_start = (CNT_W'(seg_ff) > seg_lim) ? seg_lim[IDX_W-1:0] : seg_ff;
      seg_inc   = seg_ff + IDX_W'(1);
      walk_adv  = ((CNT_W'(seg_ff) + CNT_W'(1)) < (n_cnt - CNT_W'(1)))
                  && (t_ff > rd_data.bp_time);
   end

   // table write and read address selection
   always_comb begin
      idx_ext          = CNT_W'(req_ch.point_index);
      wr_en            = req_fire && (req_ch.opcode == OP_WRITE)
                         && (idx_ext < CNT_W'(MAX_POINTS));
      wr_addr          = idx_ext[IDX_W-1:0];
      wr_data.bp_time  = req_ch.point_time;
      wr_data.bp_value = req_ch.point_value;
      rd_en            = 1'b0;
      rd_addr          = seg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rd_en   = req_fire && (req_ch.opcode == OP_QUERY) && !mode_ff;
            rd_addr = seg_start + IDX_W'(1);
         end
         ST_WALK: begin
            rd_en   = 1'b1;
            rd_addr = walk_adv ? seg_inc + IDX_W'(1) : seg_ff;
         end
         default: ;
      endcase
   end

   // segment fraction operands and the weighted difference
   always_comb begin
      div_num   = t_ff - lo_ff.bp_time;
      div_den   = hi_ff.bp_time - lo_ff.bp_time;
      div_start = (state_ff == ST_EVAL) && (t_ff >= lo_ff.bp_time) && (t_ff < hi_ff.bp_time);
      diff      = {hi_ff.bp_value[VALUE_W-1], hi_ff.bp_value}
                  - {lo_ff.bp_value[VALUE_W-1], lo_ff.bp_value};
      prod_in   = $signed({1'b0, f_ff}) * diff;
   end

   pwlti_table #(
      .DEPTH (MAX_POINTS),
      .AW    (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pwlti_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // sequencer, segment pointer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a finished result, or drop the word the receiver took
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  unique case (req_ch.opcode)
                     OP_WRITE: seg_ff <= '0;
                     OP_QUERY: begin
                        t_ff <= req_ch.query_time;
                        if (mode_ff) begin
                           res_ff    <= const_ff;
                           region_ff <= REGION_CONST;
                           state_ff  <= ST_DONE;
                        end else begin
                           seg_ff   <= seg_start;
                           state_ff <= ST_WALK;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_WALK: begin
               // advance while the next breakpoint lies before the query time
               if (walk_adv) begin
                  seg_ff <= seg_inc;
               end else begin
                  hi_ff    <= rd_data;
                  state_ff <= ST_LOAD_LO;
               end
            end
            ST_LOAD_LO: begin
               lo_ff    <= rd_data;
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               priority if (t_ff < lo_ff.bp_time) begin
                  res_ff    <= '0;
                  region_ff <= REGION_BEFORE;
                  state_ff  <= ST_DONE;
               end else if (t_ff > hi_ff.bp_time) begin
                  res_ff    <= hi_ff.bp_value;
                  region_ff <= REGION_HELD;
                  state_ff  <= ST_DONE;
               end else if (t_ff == hi_ff.bp_time) begin
                  res_ff    <= hi_ff.bp_value;
                  region_ff <= REGION_INTERP;
                  state_ff  <= ST_DONE;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  f_ff     <= div_quot;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               // arithmetic shift of the product is the floor of the division by 2^16
               res_ff    <= lo_ff.bp_value + prod_ff[FRAC_W+VALUE_W-1:FRAC_W];
               region_ff <= REGION_INTERP;
               state_ff  <= ST_DONE;
            end
            ST_DONE: begin
               // hold the result until the output register is free
               if (out_free) begin
                  out_value_ff  <= res_ff;
                  out_region_ff <= region_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.interp_value = out_value_ff;
   assign rsp_ch.region       = out_region_ff;

`ifndef SYNTHESIS
   a_seg_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(seg_ff) <= CNT_W'(MAX_POINTS - 2))
      else $error("segment pointer beyond the table");

   a_write_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_ch.opcode == OP_WRITE)) |=> (seg_ff == '0))
      else $error("write word did not clear the segment pointer");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response word loaded outside the done state");
`endif

endmodule

@@ test/piecewise_linear_time_interpolator_core_tb.sv @@
// Self-checking testbench for the piecewise linear time interpolator core.
module piecewise_linear_time_interpolator_core_tb;
   import pwlti_pkg::*;

   localparam int TABLE_DEPTH       = DEFAULT_MAX_POINTS;
   localparam int WORD_TARGET       = 1950;
   localparam int CYCLE_LIMIT       = 3000000;
   localparam int QUIET_CYCLES      = 40;
   localparam int DRAIN_CYCLES      = 300;
   localparam int IDLE_PCT          = 32;
   localparam int LONG_STALL_CYCLES = 400;
   localparam int PHASE_KINDS       = 18;

   typedef struct {
      logic                      opcode;
      logic [INDEX_W-1:0]        point_index;
      logic [TIME_W-1:0]         point_time;
      logic signed [VALUE_W-1:0] point_value;
      logic [TIME_W-1:0]         query_time;
   } word_type;

   typedef struct {
      logic signed [VALUE_W-1:0] interp_value;
      logic [REGION_W-1:0]       region;
   } answer_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [VALUE_W-1:0]   csr_wdata;

   pwlti_req_if req_if ();
   pwlti_rsp_if rsp_if ();

   piecewise_linear_time_interpolator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   word_type   words_to_send [$];
   answer_type expected_answers [$];

   // predicted table, segment pointer and registers
   logic [TIME_W-1:0]         curve_time [TABLE_DEPTH];
   logic signed [VALUE_W-1:0] curve_value [TABLE_DEPTH];
   int unsigned               curve_segment;
   logic                      cfg_const_mode;
   logic signed [VALUE_W-1:0] cfg_const_value;
   logic [COUNT_W-1:0]        cfg_point_count;

   // breakpoint times as planned by the stimulus
   logic [TIME_W-1:0] plan_time [TABLE_DEPTH];
   bit                plan_written [TABLE_DEPTH];
   longint            sweep_time;

   int words_queued   = 0;
   int words_accepted = 0;
   int fail_count     = 0;
   int unsigned cycle_count = 0;

   int req_idle_pct = IDLE_PCT;
   int rsp_idle_pct = IDLE_PCT;
   bit long_stall_go = 1'b0;
   bit long_stall_armed = 1'b0;
   int stall_left = 0;
   bit req_taken = 1'b0;

   int phase_counts [PHASE_KINDS] = '{3, 0, 16, 64, 4, 300, 1, 8, 256, 5, 511, 33, 2, 12, 128,
                                      6, 257, 20};

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Apply one accepted word to the predicted state and owe an answer for a query.
   function automatic void predict_curve(input word_type w);
      int unsigned               used;
      int unsigned               seg;
      logic [TIME_W-1:0]         t;
      logic [TIME_W-1:0]         t_lo;
      logic [TIME_W-1:0]         t_hi;
      logic signed [VALUE_W-1:0] v_lo;
      logic signed [VALUE_W-1:0] v_hi;
      longint unsigned           span;
      longint unsigned           frac;
      longint                    product;
      longint                    sum;
      answer_type                a;
      if (w.opcode == OP_WRITE) begin
         curve_time[w.point_index]  = w.point_time;
         curve_value[w.point_index] = w.point_value;
         curve_segment = 0;
         return;
      end
      if (cfg_const_mode) begin
         a.interp_value = cfg_const_value;
         a.region       = REGION_CONST;
         expected_answers.insert(expected_answers.size(), a);
         return;
      end
      used = cfg_point_count;
      if (used < 2) used = 2;
      if (used > TABLE_DEPTH) used = TABLE_DEPTH;
      t = w.query_time;
      // clamp a pointer left beyond a shrunk table, then walk forward
      seg = curve_segment;
      if (seg > used - 2) seg = used - 2;
      while (seg + 1 < used - 1 && t > curve_time[seg + 1]) seg++;
      curve_segment = seg;
      t_lo = curve_time[seg];
      t_hi = curve_time[seg + 1];
      v_lo = curve_value[seg];
      v_hi = curve_value[seg + 1];
      if (t < t_lo) begin
         a.interp_value = '0;
         a.region       = REGION_BEFORE;
      end else if (t > t_hi) begin
         a.interp_value = v_hi;
         a.region       = REGION_HELD;
      end else if (t == t_hi) begin
         a.interp_value = v_hi;
         a.region       = REGION_INTERP;
      end else begin
         span    = t_hi - t_lo;
         frac    = ({32'd0, t - t_lo} << FRAC_W) / span;
         product = longint'(frac) * (longint'(v_hi) - longint'(v_lo));
         sum     = longint'(v_lo) + (product >>> FRAC_W);
         a.interp_value = sum[VALUE_W-1:0];
         a.region       = REGION_INTERP;
      end
      expected_answers.insert(expected_answers.size(), a);
   endfunction

   function automatic void queue_write(input int idx, input logic [TIME_W-1:0] t,
                                       input logic signed [VALUE_W-1:0] v);
      word_type w;
      w.opcode      = OP_WRITE;
      w.point_index = INDEX_W'(idx);
      w.point_time  = t;
      w.point_value = v;
      w.query_time  = $urandom();
      words_to_send.insert(words_to_send.size(), w);
      plan_time[idx]    = t;
      plan_written[idx] = 1'b1;
      words_queued++;
   endfunction

   function automatic void queue_query(input logic [TIME_W-1:0] t);
      word_type w;
      w.opcode      = OP_QUERY;
      w.point_index = INDEX_W'($urandom());
      w.point_time  = $urandom();
      w.point_value = $urandom();
      w.query_time  = t;
      words_to_send.insert(words_to_send.size(), w);
      words_queued++;
   endfunction

   // Pick a query time around the planned table: sweeps, exact breakpoints, edges, noise.
   function automatic logic [TIME_W-1:0] pick_query_time(input int used);
      longint lo;
      longint hi;
      longint t;
      int     roll;
      lo   = plan_time[0];
      hi   = plan_time[used - 1];
      roll = $urandom_range(99);
      if (roll < 10) t = $urandom();
      else if (roll < 30) t = plan_time[$urandom_range(used - 1)];
      else if (roll < 38) t = lo - longint'($urandom_range(65536, 1));
      else if (roll < 44) t = hi + longint'($urandom_range(65536, 1));
      else if (hi <= lo) t = $urandom();
      else begin
         sweep_time += (hi - lo) / 32 + longint'($urandom_range(255));
         if (sweep_time < lo || sweep_time > hi) sweep_time = lo;
         t = sweep_time;
      end
      if (t < 0) t = 0;
      if (t > 64'sh0000_0000_FFFF_FFFF) t = 64'sh0000_0000_FFFF_FFFF;
      return t[TIME_W-1:0];
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_CONST_MODE:  cfg_const_mode  = data[0];
         CSR_CONST_VALUE: cfg_const_value = data;
         CSR_POINT_COUNT: cfg_point_count = data[COUNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold until every word is taken and answered, then let a trailing write finish.
   task automatic wait_idle();
      do @(negedge clock);
      while (words_accepted != words_queued || expected_answers.size() != 0);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   // request driver: advance to the next word once the current one is taken
   always @(negedge clock) begin
      word_type w;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (words_to_send.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            w = words_to_send.pop_front();
            req_if.opcode      <= w.opcode;
            req_if.point_index <= w.point_index;
            req_if.point_time  <= w.point_time;
            req_if.point_value <= w.point_value;
            req_if.query_time  <= w.query_time;
            req_if.valid       <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response ready: random stalls, plus one long hold-off counted here
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (long_stall_go && !long_stall_armed) begin
         long_stall_armed <= 1'b1;
         stall_left       <= LONG_STALL_CYCLES;
         rsp_if.ready     <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // monitor: check answers against the oldest expectation, predict taken words
   always @(posedge clock) begin
      answer_type want;
      word_type   seen;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_answers.size() == 0) begin
               $error("unexpected word: interp_value %0d region %0d",
                      rsp_if.interp_value, rsp_if.region);
               fail_count++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_if.interp_value !== want.interp_value) begin
                  $error("interp_value mismatch: expected %0d, got %0d",
                         want.interp_value, rsp_if.interp_value);
                  fail_count++;
               end
               if (rsp_if.region !== want.region) begin
                  $error("region mismatch: expected %0d, got %0d", want.region, rsp_if.region);
                  fail_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            seen.opcode      = req_if.opcode;
            seen.point_index = req_if.point_index;
            seen.point_time  = req_if.point_time;
            seen.point_value = req_if.point_value;
            seen.query_time  = req_if.query_time;
            predict_curve(seen);
            words_accepted++;
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL piecewise_linear_time_interpolator_core");
         $finish;
      end
   end

   // stimulus
   initial begin
      int                        used;
      int                        prev_used;
      int                        phase;
      int                        n_words;
      int                        count_cfg;
      int                        idx;
      bit                        do_load;
      logic [TIME_W-1:0]         t;
      logic signed [VALUE_W-1:0] v;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_CONST_MODE;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.opcode      = OP_WRITE;
      req_if.point_index = '0;
      req_if.point_time  = '0;
      req_if.point_value = '0;
      req_if.query_time  = '0;
      rsp_if.ready       = 1'b0;
      curve_segment      = 0;
      cfg_const_mode     = 1'b0;
      cfg_const_value    = '0;
      cfg_point_count    = POINT_COUNT_RESET;
      sweep_time         = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // full-range segment: before, first breakpoint, middle, just below and on the top
      queue_write(0, 32'h0001_0000, 32'h8000_0000);
      queue_write(1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      queue_query(32'h0000_0000);
      queue_query(32'h0001_0000);
      queue_query(32'h8000_0000);
      queue_query(32'hFFFF_FFFE);
      queue_query(32'hFFFF_FFFF);
      // zero-length segment, then past the end
      queue_write(1, 32'h0001_0000, 32'h0000_0005);
      queue_query(32'h0001_0000);
      queue_query(32'h0002_0000);
      // top slot, and breakpoints out of order
      queue_write(255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_write(0, 32'h0003_0000, 32'h7FFF_0000);
      queue_query(32'h0002_0000);
      queue_query(32'hFFFF_FFFF);
      // falling slope across the sign boundary
      queue_write(1, 32'h0005_0000, 32'h8001_0000);
      queue_query(32'h0004_0001);
      queue_query(32'h0003_0000);
      wait_idle();
      // constant mode at both extremes
      csr_write(CSR_CONST_MODE, 32'd1);
      csr_write(CSR_CONST_VALUE, 32'h8000_0000);
      queue_query(32'h0000_0000);
      queue_query(32'hFFFF_FFFF);
      wait_idle();
      csr_write(CSR_CONST_VALUE, 32'h7FFF_FFFF);
      queue_query(32'h1234_5678);
      wait_idle();
      csr_write(CSR_CONST_MODE, 32'd0);

      // random phases, each with its own register setting
      prev_used = 2;
      phase     = 0;
      while (words_queued < WORD_TARGET) begin
         count_cfg = phase_counts[phase % PHASE_KINDS];
         used = (count_cfg < 2) ? 2 : (count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : count_cfg;
         req_idle_pct = (phase == 2 || phase == 4) ? 0 : IDLE_PCT;
         rsp_idle_pct = (phase == 2) ? 0 : IDLE_PCT;
         if (phase == 4) long_stall_go = 1'b1;
         csr_write(CSR_CONST_MODE, (phase % 5 == 3) ? 32'd1 : 32'd0);
         csr_write(CSR_CONST_VALUE, $urandom());
         csr_write(CSR_POINT_COUNT, count_cfg);

         // load an ascending table when a slot in use is unwritten; keep it when shrinking
         do_load = 1'b0;
         for (int i = 0; i < used; i++) begin
            if (!plan_written[i]) do_load = 1'b1;
         end
         if (!do_load && used >= prev_used) do_load = ($urandom_range(99) < 40);
         if (do_load) begin
            t = $urandom_range(32'hE000_0000);
            for (int i = 0; i < used; i++) begin
               if ($urandom_range(1) == 0) v = $urandom();
               else v = $signed($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000;
               queue_write(i, t, v);
               t = t + (($urandom_range(9) == 0) ? 0 : $urandom_range(32'h0010_0000, 1));
            end
         end

         // mostly queries over the table, some rewrites that clear the pointer
         sweep_time = plan_time[0];
         n_words = (used >= 128) ? 30 : 110;
         repeat (n_words) begin
            if ($urandom_range(99) < 8) begin
               idx = $urandom_range(TABLE_DEPTH - 1);
               t = (plan_written[idx] && $urandom_range(3) != 0) ? plan_time[idx] : $urandom();
               queue_write(idx, t, $urandom());
            end else begin
               queue_query(pick_query_time(used));
            end
         end
         wait_idle();
         prev_used = used;
         phase++;
      end

      // drain: allow any stray word to show up
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_answers.size() != 0) begin
         $error("%0d expected words never arrived", expected_answers.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("PASS piecewise_linear_time_interpolator_core");
      end else begin
         $display("FAIL piecewise_linear_time_interpolator_core");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/pwlti_pkg.sv
rtl/pwlti_if.sv
rtl/pwlti_table.sv
rtl/pwlti_divider.sv
rtl/piecewise_linear_time_interpolator_core.sv
test/piecewise_linear_time_interpolator_core_tb.sv
